// File: rtl/core/lcs_pkg.sv
package lcs_pkg;
  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned MaxResults = 64;

  typedef enum logic [1:0] {
    OpAppendA = 2'd0,
    OpAppendB = 2'd1,
    OpCompute = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef struct packed {
    logic fill_start;
    logic trace_start;
    logic emit_start;
    logic emit_next;
  } lcs_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic trace_done;
    logic emit_last;
    logic empty;
  } lcs_sts_t;
endpackage

// File: rtl/core/lcs_datapath.sv
module lcs_datapath import lcs_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       app_valid_i,
  input  logic       app_sel_i,
  input  logic [7:0] app_sym_i,
  input  lcs_cmd_t   cmd_i,
  output lcs_sts_t   sts_o,
  output logic [7:0] sym_o,
  output logic [6:0] len_o,
  output logic       ovf_o
);
  localparam int unsigned LW = $clog2(MaxLen + 1);
  localparam int unsigned AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CW = $clog2(MaxLen + 2);
  localparam int unsigned TD = (MaxLen + 1) * (MaxLen + 1);
  localparam int unsigned TW = $clog2(TD);
  localparam int unsigned RD = (MaxLen < MaxResults) ? MaxLen : MaxResults;

  logic [7:0] a_mem [MaxLen];
  logic [7:0] b_mem [MaxLen];
  logic [CW-1:0] tbl [TD];
  logic [7:0] rev_mem [MaxLen];

  logic [LW-1:0] alen_q, blen_q;
  logic          ovf_q;
  logic [LW-1:0] i_q, j_q;
  logic [LW-1:0] cnt_q, k_q;
  logic          fill_q, trace_q;
  logic          fill_done_q, trace_done_q;
  logic [1:0]    ph_q;
  logic [7:0]    ai_q, bj_q;
  logic [CW-1:0] up_q, cur_q;
  logic [CW-1:0] left_run_q;
  logic [CW-1:0] rd_q;

  function automatic logic [TW-1:0] addr(input logic [LW-1:0] r, input logic [LW-1:0] c);
    logic [TW+LW-1:0] t;
    t = (TW+LW)'(r) * (TW+LW)'(MaxLen + 1) + (TW+LW)'(c);
    return t[TW-1:0];
  endfunction

  logic [LW-1:0] im1, jm1;
  assign im1 = i_q - 1'b1;
  assign jm1 = j_q - 1'b1;

  logic [LW-1:0] kn;
  assign kn = cmd_i.emit_next ? k_q + 1'b1 : k_q;

  logic [CW-1:0] dg_v;
  assign dg_v = (im1 == '0 || jm1 == '0) ? '0 : rd_q;

  logic [CW-1:0] cell_v;
  always_comb begin
    if (ai_q == bj_q) cell_v = dg_v + 1'b1;
    else cell_v = (up_q > left_run_q) ? up_q : left_run_q;
  end

  logic cell_last;
  assign cell_last = (j_q == blen_q) && (i_q == alen_q);

  logic trace_end;
  always_comb begin
    if (ai_q == bj_q) trace_end = (im1 == '0) || (jm1 == '0);
    else if (cur_q == up_q) trace_end = (im1 == '0);
    else trace_end = (jm1 == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alen_q <= '0; blen_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; cnt_q <= '0; k_q <= '0;
      fill_q <= 1'b0; trace_q <= 1'b0; ph_q <= '0;
      fill_done_q <= 1'b0; trace_done_q <= 1'b0;
    end else begin
      fill_done_q <= cmd_i.fill_start ? ((alen_q == '0) || (blen_q == '0))
                                      : (fill_q && ph_q == 2'd2 && cell_last);
      trace_done_q <= cmd_i.trace_start ? ((alen_q == '0) || (blen_q == '0))
                                        : (trace_q && ph_q == 2'd2 && trace_end);
      if (app_valid_i) begin
        if (!app_sel_i) begin
          if (alen_q >= LW'(MaxLen)) ovf_q <= 1'b1;
          else alen_q <= alen_q + 1'b1;
        end else begin
          if (blen_q >= LW'(MaxLen)) ovf_q <= 1'b1;
          else blen_q <= blen_q + 1'b1;
        end
      end
      if (cmd_i.fill_start) begin
        i_q <= LW'(1); j_q <= LW'(1); ph_q <= '0;
        fill_q <= (alen_q != '0) && (blen_q != '0);
      end else if (fill_q) begin
        ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          if (j_q == blen_q) begin
            j_q <= LW'(1);
            if (i_q == alen_q) fill_q <= 1'b0;
            else i_q <= i_q + 1'b1;
          end else j_q <= j_q + 1'b1;
        end
      end
      if (cmd_i.trace_start) begin
        i_q <= alen_q; j_q <= blen_q; cnt_q <= '0; ph_q <= '0;
        trace_q <= (alen_q != '0) && (blen_q != '0);
      end else if (trace_q) begin
        ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 1'b1;
        if (ph_q == 2'd2) begin
          if (trace_end) trace_q <= 1'b0;
          if (ai_q == bj_q) begin
            if (cnt_q < LW'(MaxLen)) cnt_q <= cnt_q + 1'b1;
            i_q <= im1; j_q <= jm1;
          end else if (cur_q == up_q) i_q <= im1;
          else j_q <= jm1;
        end
      end
      if (cmd_i.emit_start) k_q <= '0;
      else if (cmd_i.emit_next) k_q <= k_q + 1'b1;
    end
  end

  // memories and operand fetch
  always_ff @(posedge clk_i) begin
    if (app_valid_i && !app_sel_i && alen_q < LW'(MaxLen)) a_mem[alen_q[AW-1:0]] <= app_sym_i;
    if (app_valid_i && app_sel_i && blen_q < LW'(MaxLen)) b_mem[blen_q[AW-1:0]] <= app_sym_i;
    ai_q <= a_mem[im1[AW-1:0]];
    bj_q <= b_mem[jm1[AW-1:0]];
    if (cmd_i.fill_start) left_run_q <= '0;
    else if (fill_q && ph_q == 2'd2) left_run_q <= (j_q == blen_q) ? '0 : cell_v;
    if (fill_q || trace_q) begin
      case (ph_q)
        2'd0: rd_q <= tbl[addr(im1, j_q)];
        2'd1: begin
          up_q <= (im1 == '0) ? '0 : rd_q;
          rd_q <= tbl[addr(im1, jm1)];
        end
        default: ;
      endcase
    end
    if (fill_q && ph_q == 2'd2) tbl[addr(i_q, j_q)] <= cell_v;
    if (trace_q && ph_q == 2'd0) cur_q <= tbl[addr(i_q, j_q)];
    if (trace_q && ph_q == 2'd2 && ai_q == bj_q && cnt_q < LW'(MaxLen))
      rev_mem[cnt_q[AW-1:0]] <= ai_q;
    sym_o <= rev_mem[AW'(cnt_q - 1'b1 - kn)];
  end

  assign len_o = 7'(cnt_q);
  assign ovf_o = ovf_q;
  assign sts_o = '{
    fill_done:  fill_done_q,
    trace_done: trace_done_q,
    emit_last:  (kn + 1'b1 == ((cnt_q > LW'(RD)) ? LW'(RD) : cnt_q)),
    empty:      (cnt_q == '0)
  };
endmodule

// File: rtl/core/lcs_ctrl.sv
module lcs_ctrl import lcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] in_op_i,
  output logic     in_ready_o,
  output lcs_cmd_t cmd_o,
  input  lcs_sts_t sts_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_last_o,
  output logic     out_empty_o
);
  typedef enum logic [2:0] {SIdle, SFill, STrace, SLoad, SEmit} state_e;
  state_e state_q;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    cmd_o = '0;
    cmd_o.fill_start = (state_q == SIdle) && in_valid_i && (in_op_i == OpCompute);
    cmd_o.trace_start = (state_q == SFill) && sts_i.fill_done;
    cmd_o.emit_start = (state_q == STrace) && sts_i.trace_done;
    cmd_o.emit_next = (state_q == SEmit) && out_ready_i && !out_last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; out_valid_o <= 1'b0; out_last_o <= 1'b0; out_empty_o <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (cmd_o.fill_start) state_q <= SFill;
        SFill: if (sts_i.fill_done) state_q <= STrace;
        STrace: if (sts_i.trace_done) state_q <= SLoad;
        SLoad: begin
          state_q <= SEmit; out_valid_o <= 1'b1;
          out_empty_o <= sts_i.empty;
          out_last_o <= sts_i.empty || sts_i.emit_last;
        end
        SEmit: if (out_ready_i) begin
          if (out_last_o) begin
            out_valid_o <= 1'b0; out_last_o <= 1'b0; state_q <= SIdle;
          end else out_last_o <= sts_i.emit_last;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: rtl/core/lcs_table_with_traceback_top.sv
// lcs table with traceback
// slave side: words carry opcode and symbol; opcodes append a byte to the
// first or second string, or start a compute run. appends are accepted back
// to back while no compute run is in progress. appends past MaxLen are dropped
// and set a sticky truncated flag.
// a compute word holds s_axis_tready low while the table fills (m*n cells)
// and the trace runs (up to m+n-1 steps). then one word per common symbol
// leaves on the master side in forward order, tlast on the final one; an
// empty result gives one word flagged empty. the master side holds its word
// while m_axis_tready is low; no new input is taken until the run is
// delivered.
// reset clears string lengths and the truncated flag; no clearing pass.
module lcs_table_with_traceback_top import lcs_pkg::*; #(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // opcode, symbol
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [15:0] m_axis_tdata,  // out_symbol, lcs_length
  output logic        m_axis_tlast,  // last_item
  output logic [1:0]  m_axis_tuser   // empty_result, truncated
);
  lcs_cmd_t cmd;
  lcs_sts_t sts;
  logic [7:0] sym;
  logic [6:0] len;
  logic ovf, empty;
  logic acc_app;

  assign acc_app = s_axis_tvalid && s_axis_tready &&
                   (s_axis_tdata[1:0] == OpAppendA || s_axis_tdata[1:0] == OpAppendB);

  lcs_datapath #(.MaxLen(MaxLen)) u_dp (
    .clk_i, .rst_ni, .app_valid_i(acc_app), .app_sel_i(s_axis_tdata[0]),
    .app_sym_i(s_axis_tdata[9:2]), .cmd_i(cmd), .sts_o(sts),
    .sym_o(sym), .len_o(len), .ovf_o(ovf)
  );

  lcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_op_i(s_axis_tdata[1:0]),
    .in_ready_o(s_axis_tready), .cmd_o(cmd), .sts_i(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_o(m_axis_tlast), .out_empty_o(empty)
  );

  assign m_axis_tdata = empty ? 16'd0 : {1'b0, len, sym};
  assign m_axis_tuser = {ovf, empty};

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> m_axis_tvalid) else $error("tlast without tvalid");
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
endmodule
